@@ design/anf_pkg.sv @@
// ----------------------------------------------------------------------------
// anf_pkg
// Shared types, constants and the microcode program of the adaptive notch
// filter core.
// ----------------------------------------------------------------------------
package anf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int WORD_W     = 32;
   localparam int ACC_W      = 64;
   localparam int OPND_W     = 33;
   localparam int CFG_W      = 15;
   localparam int CSR_ADDR_W = 2;
   localparam int SH_W       = 5;
   localparam int HIST_DEPTH = 3;

   localparam logic [CFG_W-1:0] FORGET_RESET = 15'd31130;
   localparam logic [CFG_W-1:0] STEP_RESET   = 15'd328;
   localparam logic [CFG_W-1:0] LIMIT_RESET  = 15'd32113;
   localparam logic [CFG_W-1:0] START_RESET  = 15'd26214;
   localparam logic [CFG_W-1:0] Q15_ONE      = 15'd32767;

   localparam int UCODE_LEN = 22;
   localparam int PC_W      = $clog2(UCODE_LEN);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FORGET = 2'd0,
      CSR_STEP   = 2'd1,
      CSR_LIMIT  = 2'd2,
      CSR_START  = 2'd3
   } csr_addr_type;

   typedef enum logic [1:0] {
      SEQ_NEXT    = 2'd0,
      SEQ_WAIT_IN = 2'd1,
      SEQ_EMIT    = 2'd2,
      SEQ_RESTART = 2'd3
   } seq_type;

   typedef enum logic [2:0] {
      MA_FF   = 3'd0,
      MA_NFF  = 3'd1,
      MA_HALF = 3'd2,
      MA_CR   = 3'd3,
      MA_A    = 3'd4,
      MA_E    = 3'd5,
      MA_TLO  = 3'd6,
      MA_THI  = 3'd7
   } mula_type;

   typedef enum logic [2:0] {
      MB_CR = 3'd0,
      MB_RL = 3'd1,
      MB_A  = 3'd2,
      MB_H1 = 3'd3,
      MB_H2 = 3'd4,
      MB_MU = 3'd5
   } mulb_type;

   typedef enum logic [2:0] {
      XS_P    = 3'd0,
      XS_T    = 3'd1,
      XS_U    = 3'd2,
      XS_YSH  = 3'd3,
      XS_HK14 = 3'd4,
      XS_A    = 3'd5
   } alux_type;

   typedef enum logic [2:0] {
      YS_ZERO  = 3'd0,
      YS_P     = 3'd1,
      YS_PHI   = 3'd2,
      YS_U     = 3'd3,
      YS_HM214 = 3'd4
   } aluy_type;

   typedef enum logic [2:0] {
      DST_NONE = 3'd0,
      DST_T    = 3'd1,
      DST_U    = 3'd2,
      DST_CR   = 3'd3,
      DST_HK   = 3'd4,
      DST_E    = 3'd5,
      DST_A    = 3'd6
   } dest_type;

   typedef struct packed {
      seq_type          seq;
      logic             mul_en;
      mula_type         mul_a;
      mulb_type         mul_b;
      alux_type         x;
      aluy_type         y;
      logic             neg;
      logic [SH_W-1:0]  sh;
      dest_type         dst;
   } ctrl_type;

   typedef struct packed {
      logic ready;
      logic emit;
   } seq_stat_type;

   typedef struct packed {
      logic [CFG_W-1:0] ff;
      logic [CFG_W-1:0] mu;
      logic [CFG_W-1:0] rl;
      logic             start_we;
      logic [CFG_W-1:0] start_val;
   } cfg_type;

   // control program, one word per step; rounding constant follows the shift
   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type w;
      w.seq    = SEQ_NEXT;
      w.mul_en = 1'b0;
      w.mul_a  = MA_FF;
      w.mul_b  = MB_CR;
      w.x      = XS_P;
      w.y      = YS_ZERO;
      w.neg    = 1'b0;
      w.sh     = 5'd0;
      w.dst    = DST_NONE;
      case (pc)
         5'd0: begin
            w.seq = SEQ_WAIT_IN;
         end
         // radius update
         5'd1: begin
            w.mul_en = 1'b1; w.mul_a = MA_FF; w.mul_b = MB_CR;
         end
         5'd2: begin
            w.mul_en = 1'b1; w.mul_a = MA_NFF; w.mul_b = MB_RL;
            w.x = XS_P; w.dst = DST_T;
         end
         5'd3: begin
            w.x = XS_T; w.y = YS_P; w.sh = 5'd15; w.dst = DST_CR;
         end
         // new history value
         5'd4: begin
            w.mul_en = 1'b1; w.mul_a = MA_HALF; w.mul_b = MB_A;
         end
         5'd5: begin
            w.x = XS_P; w.sh = 5'd16; w.dst = DST_T;
         end
         5'd6: begin
            w.mul_en = 1'b1; w.mul_a = MA_TLO; w.mul_b = MB_H1;
         end
         5'd7: begin
            w.mul_en = 1'b1; w.mul_a = MA_THI; w.mul_b = MB_H1;
            w.x = XS_P; w.dst = DST_U;
         end
         5'd8: begin
            w.mul_en = 1'b1; w.mul_a = MA_CR; w.mul_b = MB_CR;
            w.x = XS_U; w.y = YS_PHI; w.dst = DST_U;
         end
         5'd9: begin
            w.x = XS_P; w.sh = 5'd18; w.dst = DST_T;
         end
         5'd10: begin
            w.mul_en = 1'b1; w.mul_a = MA_TLO; w.mul_b = MB_H2;
            w.x = XS_YSH; w.y = YS_U; w.dst = DST_U;
         end
         5'd11: begin
            w.mul_en = 1'b1; w.mul_a = MA_THI; w.mul_b = MB_H2;
            w.x = XS_U; w.y = YS_P; w.neg = 1'b1; w.dst = DST_U;
         end
         5'd12: begin
            w.mul_en = 1'b1; w.mul_a = MA_A; w.mul_b = MB_H1;
            w.x = XS_U; w.y = YS_PHI; w.neg = 1'b1; w.sh = 5'd12; w.dst = DST_HK;
         end
         // error output
         5'd13: begin
            w.x = XS_HK14; w.y = YS_HM214; w.dst = DST_T;
         end
         5'd14: begin
            w.x = XS_T; w.y = YS_P; w.neg = 1'b1; w.sh = 5'd11; w.dst = DST_E;
         end
         // coefficient update
         5'd15: begin
            w.mul_en = 1'b1; w.mul_a = MA_E; w.mul_b = MB_H1;
         end
         5'd16: begin
            w.x = XS_P; w.sh = 5'd13; w.dst = DST_T;
         end
         5'd17: begin
            w.mul_en = 1'b1; w.mul_a = MA_TLO; w.mul_b = MB_MU;
         end
         5'd18: begin
            w.mul_en = 1'b1; w.mul_a = MA_THI; w.mul_b = MB_MU;
            w.x = XS_P; w.dst = DST_U;
         end
         5'd19: begin
            w.x = XS_U; w.y = YS_PHI; w.sh = 5'd14; w.dst = DST_U;
         end
         5'd20: begin
            w.x = XS_A; w.y = YS_U; w.dst = DST_A;
         end
         5'd21: begin
            w.seq = SEQ_EMIT;
         end
         default: begin
            w.seq = SEQ_RESTART;
         end
      endcase
      return w;
   endfunction

endpackage

@@ design/anf_sequencer.sv @@
// ----------------------------------------------------------------------------
// anf_sequencer
// Step counter with the microcode table; waits for a sample at the first
// step and for a free result register at the last.
// ----------------------------------------------------------------------------
module anf_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  out_free,
   output anf_pkg::ctrl_type     ctrl,
   output anf_pkg::seq_stat_type stat
);

   logic [anf_pkg::PC_W-1:0] pc_ff;
   logic [anf_pkg::PC_W-1:0] pc_in;

   assign ctrl = anf_pkg::ucode(pc_ff);

   always_comb begin
      stat.ready = 1'b0;
      stat.emit  = 1'b0;
      unique case (ctrl.seq)
         anf_pkg::SEQ_NEXT: begin
            pc_in = pc_ff + anf_pkg::PC_W'(1);
         end
         anf_pkg::SEQ_WAIT_IN: begin
            stat.ready = 1'b1;
            pc_in      = req_tvalid ? pc_ff + anf_pkg::PC_W'(1) : pc_ff;
         end
         anf_pkg::SEQ_EMIT: begin
            stat.emit = out_free;
            pc_in     = out_free ? '0 : pc_ff;
         end
         default: begin
            pc_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ design/anf_datapath.sv @@
// ----------------------------------------------------------------------------
// anf_datapath
// Shared 33x33 multiplier, 64-bit add/round/shift unit and the filter state,
// driven one control word per cycle.
// ----------------------------------------------------------------------------
module anf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  anf_pkg::ctrl_type                   ctrl,
   input  anf_pkg::seq_stat_type               stat,
   input  logic                                take,
   input  logic [anf_pkg::SAMPLE_W-1:0]        sample,
   input  anf_pkg::cfg_type                    cfg,
   output logic [anf_pkg::WORD_W-1:0]          err,
   output logic [anf_pkg::WORD_W-1:0]          coeff
);

   localparam int W  = anf_pkg::WORD_W;
   localparam int AW = anf_pkg::ACC_W;
   localparam int OW = anf_pkg::OPND_W;

   logic [anf_pkg::SAMPLE_W-1:0] y_ff;
   logic [AW-1:0]                p_ff;
   logic [AW-1:0]                t_ff;
   logic [AW-1:0]                u_ff;
   logic [W-1:0]                 e_ff;
   logic [W-1:0]                 cr_ff;
   logic [W-1:0]                 a_ff;
   logic [W-1:0]                 hist_ff [anf_pkg::HIST_DEPTH];

   logic [anf_pkg::CFG_W-1:0]    nff;
   logic [OW-1:0]                half;
   logic signed [OW-1:0]         mul_a;
   logic signed [OW-1:0]         mul_b;
   logic signed [2*OW-1:0]       prod;
   logic [AW-1:0]                alu_x;
   logic [AW-1:0]                alu_y;
   logic [AW-1:0]                alu_rnd;
   logic [AW-1:0]                alu_sum;
   logic [AW-1:0]                alu_res;

   assign nff  = anf_pkg::Q15_ONE - cfg.ff;
   // (r + 1) >> 1 with sign kept
   assign half = OW'($signed({cr_ff[W-1], cr_ff} + OW'(1)) >>> 1);

   always_comb begin
      unique case (ctrl.mul_a)
         anf_pkg::MA_FF:   mul_a = $signed({{(OW-anf_pkg::CFG_W){1'b0}}, cfg.ff});
         anf_pkg::MA_NFF:  mul_a = $signed({{(OW-anf_pkg::CFG_W){1'b0}}, nff});
         anf_pkg::MA_HALF: mul_a = $signed(half);
         anf_pkg::MA_CR:   mul_a = $signed({cr_ff[W-1], cr_ff});
         anf_pkg::MA_A:    mul_a = $signed({a_ff[W-1], a_ff});
         anf_pkg::MA_E:    mul_a = $signed({e_ff[W-1], e_ff});
         anf_pkg::MA_TLO:  mul_a = $signed({1'b0, t_ff[W-1:0]});
         anf_pkg::MA_THI:  mul_a = $signed({t_ff[AW-1], t_ff[AW-1:W]});
         default:          mul_a = '0;
      endcase
      unique case (ctrl.mul_b)
         anf_pkg::MB_CR: mul_b = $signed({cr_ff[W-1], cr_ff});
         anf_pkg::MB_RL: mul_b = $signed({{(OW-anf_pkg::CFG_W){1'b0}}, cfg.rl});
         anf_pkg::MB_A:  mul_b = $signed({a_ff[W-1], a_ff});
         anf_pkg::MB_H1: mul_b = $signed({hist_ff[1][W-1], hist_ff[1]});
         anf_pkg::MB_H2: mul_b = $signed({hist_ff[2][W-1], hist_ff[2]});
         anf_pkg::MB_MU: mul_b = $signed({{(OW-anf_pkg::CFG_W){1'b0}}, cfg.mu});
         default:        mul_b = '0;
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      unique case (ctrl.x)
         anf_pkg::XS_P:    alu_x = p_ff;
         anf_pkg::XS_T:    alu_x = t_ff;
         anf_pkg::XS_U:    alu_x = u_ff;
         anf_pkg::XS_YSH:  alu_x = {{(AW-anf_pkg::SAMPLE_W-9){y_ff[anf_pkg::SAMPLE_W-1]}},
                                     y_ff, 9'd0};
         anf_pkg::XS_HK14: alu_x = {{(AW-W-14){hist_ff[0][W-1]}}, hist_ff[0], 14'd0};
         anf_pkg::XS_A:    alu_x = {{(AW-W){a_ff[W-1]}}, a_ff};
         default:          alu_x = '0;
      endcase
      unique case (ctrl.y)
         anf_pkg::YS_ZERO:  alu_y = '0;
         anf_pkg::YS_P:     alu_y = p_ff;
         anf_pkg::YS_PHI:   alu_y = {p_ff[W-1:0], {W{1'b0}}};
         anf_pkg::YS_U:     alu_y = u_ff;
         anf_pkg::YS_HM214: alu_y = {{(AW-W-14){hist_ff[2][W-1]}}, hist_ff[2], 14'd0};
         default:           alu_y = '0;
      endcase
      // half-up rounding constant sits one bit below the shift
      alu_rnd = (ctrl.sh == '0) ? '0 : (AW'(1) << (ctrl.sh - anf_pkg::SH_W'(1)));
      alu_sum = alu_x + (ctrl.neg ? (~alu_y + AW'(1)) : alu_y) + alu_rnd;
      alu_res = AW'($signed(alu_sum) >>> ctrl.sh);
   end

   always_ff @(posedge clock) begin
      if (take) begin
         y_ff <= sample;
      end
      if (ctrl.mul_en) begin
         p_ff <= prod[AW-1:0];
      end
      if (ctrl.dst == anf_pkg::DST_T) begin
         t_ff <= alu_res;
      end
      if (ctrl.dst == anf_pkg::DST_U) begin
         u_ff <= alu_res;
      end
      if (ctrl.dst == anf_pkg::DST_E) begin
         e_ff <= alu_res[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_ff      <= W'(anf_pkg::START_RESET);
         a_ff       <= '0;
         hist_ff[0] <= '0;
         hist_ff[1] <= '0;
         hist_ff[2] <= '0;
      end else begin
         if (cfg.start_we) begin
            cr_ff <= W'(cfg.start_val);
         end else if (ctrl.dst == anf_pkg::DST_CR) begin
            cr_ff <= alu_res[W-1:0];
         end
         if (ctrl.dst == anf_pkg::DST_A) begin
            a_ff <= alu_res[W-1:0];
         end
         if (ctrl.dst == anf_pkg::DST_HK) begin
            hist_ff[0] <= alu_res[W-1:0];
         end
         // history ages once per sample, newest in slot zero
         if (stat.emit) begin
            hist_ff[1] <= hist_ff[0];
            hist_ff[2] <= hist_ff[1];
         end
      end
   end

   assign err   = e_ff;
   assign coeff = a_ff;

endmodule

@@ design/adaptive_notch_filter_q15_core.sv @@
// ----------------------------------------------------------------------------
// adaptive_notch_filter_q15_core
// Q15 adaptive notch filter with LMS coefficient update, run by a microcoded
// sequencer over one shared multiplier.
//
//   channel   dir   payload                           transfer when
//   req_      in    tdata[15:0] sample_in             req_tvalid & req_tready
//   rsp_      out   tdata[31:0] notch_out,            rsp_tvalid & rsp_tready
//                   tdata[63:32] coeff_now
//   csr_      in    addr 0..3, wdata[14:0]            csr_we
//
// a sample is taken at step zero; its result is registered at the last step,
// and no new sample is accepted until that result is registered
// the program length is set by the single 33x33 multiplier: twelve products, three of
// them 64-bit wrapping products done as two halves
// reset is synchronous; config registers return to their defaults, radius to start
// a result not yet taken holds the program at its last step; the next sample
// is not accepted while it waits
// ----------------------------------------------------------------------------
module adaptive_notch_filter_q15_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // [15:0] sample_in
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,   // [31:0] notch_out, [63:32] coeff_now
   input  logic                               csr_we,
   input  logic [anf_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [anf_pkg::CFG_W-1:0]          csr_wdata
);

   logic [anf_pkg::CFG_W-1:0]  ff_ff;
   logic [anf_pkg::CFG_W-1:0]  mu_ff;
   logic [anf_pkg::CFG_W-1:0]  rl_ff;
   logic                       rsp_valid_ff;
   logic [63:0]                rsp_data_ff;

   anf_pkg::ctrl_type          ctrl;
   anf_pkg::seq_stat_type      stat;
   anf_pkg::cfg_type           cfg;
   logic                       out_free;
   logic                       take;
   logic [anf_pkg::WORD_W-1:0] err;
   logic [anf_pkg::WORD_W-1:0] coeff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = stat.ready;
   assign take       = req_tvalid && stat.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_ff <= anf_pkg::FORGET_RESET;
         mu_ff <= anf_pkg::STEP_RESET;
         rl_ff <= anf_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (anf_pkg::csr_addr_type'(csr_addr))
            anf_pkg::CSR_FORGET: ff_ff <= csr_wdata;
            anf_pkg::CSR_STEP:   mu_ff <= csr_wdata;
            anf_pkg::CSR_LIMIT:  rl_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // the start radius is not stored, a write loads the running radius
   assign cfg.ff        = ff_ff;
   assign cfg.mu        = mu_ff;
   assign cfg.rl        = rl_ff;
   assign cfg.start_we  = csr_we && (csr_addr == anf_pkg::CSR_START);
   assign cfg.start_val = csr_wdata;

   anf_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .ctrl       (ctrl),
      .stat       (stat)
   );

   anf_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .stat   (stat),
      .take   (take),
      .sample (req_tdata),
      .cfg    (cfg),
      .err    (err),
      .coeff  (coeff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.emit) begin
         rsp_data_ff <= {coeff, err};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_emit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      stat.emit |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten before transfer");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      stat.emit |=> rsp_tvalid)
      else $error("emitted result not presented");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second sample taken while one is in progress");

   a_no_take_at_emit: assert property (@(posedge clock) disable iff (reset)
      stat.emit |-> !req_tready)
      else $error("sample taken during result step");

endmodule
